### hw/rtl/msfp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// msfp_pkg
// Shared types, constants and the CRC-16 byte update for the motor status
// frame parser.
// ---------------------------------------------------------------------------
package msfp_pkg;

  // Frame format
  localparam int unsigned MAX_PAYLOAD = 80;
  localparam int unsigned LEN_W       = $clog2(MAX_PAYLOAD + 1);
  localparam logic [7:0]  START_BYTE  = 8'd2;
  localparam logic [7:0]  END_BYTE    = 8'd3;
  localparam logic [7:0]  STATUS_CMD  = 8'd4;
  localparam logic [LEN_W-1:0] MIN_LEN = LEN_W'(29);
  localparam logic [15:0] CRC_POLY    = 16'h1021;

  // Payload byte positions of the captured fields
  localparam logic [LEN_W-1:0] IDX_CMD      = LEN_W'(0);
  localparam logic [LEN_W-1:0] IDX_CUR_LO   = LEN_W'(9);
  localparam logic [LEN_W-1:0] IDX_CUR_HI   = LEN_W'(12);
  localparam logic [LEN_W-1:0] IDX_DUTY_LO  = LEN_W'(21);
  localparam logic [LEN_W-1:0] IDX_DUTY_HI  = LEN_W'(22);
  localparam logic [LEN_W-1:0] IDX_RPM_LO   = LEN_W'(23);
  localparam logic [LEN_W-1:0] IDX_RPM_HI   = LEN_W'(26);
  localparam logic [LEN_W-1:0] IDX_VOLT_LO  = LEN_W'(27);
  localparam logic [LEN_W-1:0] IDX_VOLT_HI  = LEN_W'(28);

  typedef enum logic [2:0] {
    PH_HUNT = 3'd0,
    PH_LEN  = 3'd1,
    PH_DATA = 3'd2,
    PH_CRCH = 3'd3,
    PH_CRCL = 3'd4,
    PH_END  = 3'd5
  } phase_t;

  // One decoded status result
  typedef struct packed {
    logic signed [31:0] motor_current;
    logic signed [15:0] duty_cycle;
    logic signed [31:0] electrical_rpm;
    logic signed [15:0] input_voltage;
  } status_t;

  // CRC-16/XMODEM, one byte, MSB first
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage
`default_nettype wire

### hw/rtl/msfp_in_reg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// msfp_in_reg
// Input register stage: holds one received byte for the parser.
// ---------------------------------------------------------------------------
module msfp_in_reg
  import msfp_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] rx_byte,
  output logic            byte_valid,
  output logic [7:0]      byte_data,
  input  wire logic       byte_take
);

  // Accept when empty or when the held byte leaves this cycle
  assign in_ready = !byte_valid || byte_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else if (in_ready) begin
      byte_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_data <= rx_byte;
    end
  end

endmodule
`default_nettype wire

### hw/rtl/msfp_parser.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// msfp_parser
// Frame state machine: length check, per-byte CRC, field capture and the
// final frame check.
// ---------------------------------------------------------------------------
module msfp_parser
  import msfp_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       byte_valid,
  input  wire logic [7:0] byte_data,
  output logic            byte_take,
  input  wire logic       res_space,
  output logic            res_load,
  output status_t         res_data
);

  phase_t            phase, phase_next;
  logic [LEN_W-1:0]  payload_length;
  logic [LEN_W-1:0]  byte_index;
  logic [LEN_W-1:0]  index_inc;
  logic [15:0]       running_crc;
  logic [15:0]       received_crc;
  logic [7:0]        command_byte;
  logic [31:0]       current_capture;
  logic [15:0]       duty_capture;
  logic [31:0]       rpm_capture;
  logic [15:0]       voltage_capture;
  logic              len_ok;
  logic              frame_ok;

  // Only the end byte can produce a result, so only it waits on output space
  assign byte_take = byte_valid && ((phase != PH_END) || res_space);

  assign index_inc = byte_index + LEN_W'(1);
  assign len_ok    = (byte_data != 8'd0) && ({1'b0, byte_data} <= 9'(MAX_PAYLOAD));
  assign frame_ok  = (byte_data == END_BYTE) && (received_crc == running_crc) &&
                     (payload_length >= MIN_LEN) && (command_byte == STATUS_CMD);

  // Next phase and result strobe
  always_comb begin
    phase_next = phase;
    res_load   = 1'b0;
    if (byte_take) begin
      unique case (phase)
        PH_HUNT: if (byte_data == START_BYTE) phase_next = PH_LEN;
        PH_LEN:  phase_next = len_ok ? PH_DATA : PH_HUNT;
        PH_DATA: if (index_inc >= payload_length) phase_next = PH_CRCH;
        PH_CRCH: phase_next = PH_CRCL;
        PH_CRCL: phase_next = PH_END;
        PH_END: begin
          res_load   = frame_ok;
          phase_next = PH_HUNT;
        end
        default: phase_next = PH_HUNT;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HUNT;
    end else begin
      phase <= phase_next;
    end
  end

  // Length, index, CRC and capture registers
  always_ff @(posedge clk) begin
    if (rst) begin
      payload_length  <= '0;
      byte_index      <= '0;
      running_crc     <= '0;
      received_crc    <= '0;
      command_byte    <= '0;
      current_capture <= '0;
      duty_capture    <= '0;
      rpm_capture     <= '0;
      voltage_capture <= '0;
    end else if (byte_take) begin
      unique case (phase)
        PH_LEN: begin
          payload_length <= byte_data[LEN_W-1:0];
          byte_index     <= '0;
          running_crc    <= '0;
        end
        PH_DATA: begin
          running_crc <= crc_byte(running_crc, byte_data);
          byte_index  <= index_inc;
          if (byte_index == IDX_CMD) begin
            command_byte <= byte_data;
          end else if (byte_index >= IDX_CUR_LO && byte_index <= IDX_CUR_HI) begin
            current_capture <= {current_capture[23:0], byte_data};
          end else if (byte_index >= IDX_DUTY_LO && byte_index <= IDX_DUTY_HI) begin
            duty_capture <= {duty_capture[7:0], byte_data};
          end else if (byte_index >= IDX_RPM_LO && byte_index <= IDX_RPM_HI) begin
            rpm_capture <= {rpm_capture[23:0], byte_data};
          end else if (byte_index >= IDX_VOLT_LO && byte_index <= IDX_VOLT_HI) begin
            voltage_capture <= {voltage_capture[7:0], byte_data};
          end
        end
        PH_CRCH: received_crc <= {byte_data, 8'h00};
        PH_CRCL: received_crc <= {received_crc[15:8], byte_data};
        default: ;
      endcase
    end
  end

  assign res_data.motor_current  = current_capture;
  assign res_data.duty_cycle     = duty_capture;
  assign res_data.electrical_rpm = rpm_capture;
  assign res_data.input_voltage  = voltage_capture;

endmodule
`default_nettype wire

### hw/rtl/msfp_out_reg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// msfp_out_reg
// Result register: holds one status transaction until the sink takes it.
// ---------------------------------------------------------------------------
module msfp_out_reg
  import msfp_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    res_load,
  input  status_t      res_data,
  output logic         res_space,
  output logic         out_valid,
  input  wire logic    out_ready,
  output status_t      out_data
);

  assign res_space = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_data <= res_data;
    end
  end

endmodule
`default_nettype wire

### hw/rtl/motor_status_frame_parser_unit.sv
// Order: a byte is registered on accept and then parsed; a status result
// is registered on the output the cycle after the parser takes its end byte.
// Throughput: one byte per cycle; the parser stalls only on an end byte while
// the result register is full and not being taken.
// Reset (rst, synchronous): parser returns to hunting for the start byte,
// all frame state is cleared and both register stages are emptied.
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// motor_status_frame_parser_unit
// Deframes serial bytes into motor status results (CRC-16/XMODEM checked).
// ---------------------------------------------------------------------------
module motor_status_frame_parser_unit
  import msfp_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [7:0]         rx_byte,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [31:0]      motor_current,
  output logic signed [15:0]      duty_cycle,
  output logic signed [31:0]      electrical_rpm,
  output logic signed [15:0]      input_voltage
);

  logic       byte_valid;
  logic [7:0] byte_data;
  logic       byte_take;
  logic       res_space;
  logic       res_load;
  status_t    res_data;
  status_t    out_data;

  // Input byte register
  msfp_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .rx_byte    (rx_byte),
    .byte_valid (byte_valid),
    .byte_data  (byte_data),
    .byte_take  (byte_take)
  );

  // Frame parser
  msfp_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_data  (byte_data),
    .byte_take  (byte_take),
    .res_space  (res_space),
    .res_load   (res_load),
    .res_data   (res_data)
  );

  // Result register
  msfp_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .res_load  (res_load),
    .res_data  (res_data),
    .res_space (res_space),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  assign motor_current  = out_data.motor_current;
  assign duty_cycle     = out_data.duty_cycle;
  assign electrical_rpm = out_data.electrical_rpm;
  assign input_voltage  = out_data.input_voltage;

endmodule
`default_nettype wire
